@@ rtl/core/i2c_target_register_bank_defines.svh @@
// Assertion macros for the I2C target register bank.
// Included by the top level; no other dependencies.
`ifndef I2C_TARGET_REGISTER_BANK_DEFINES_SVH
`define I2C_TARGET_REGISTER_BANK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/i2crb_pkg.sv @@
// Types and constants shared by the I2C target register bank.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2crb_pkg;

   localparam int BANK_DEPTH = 16;
   localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int PTR_W      = $clog2(BANK_DEPTH + 1);

   localparam logic [7:0] TX_EMPTY = 8'hFF;

   typedef enum logic [1:0] {
      REPLY_NONE = 2'd0,
      REPLY_ACK  = 2'd1,
      REPLY_NACK = 2'd2
   } reply_type;

   typedef struct packed {
      logic       event_fault;
      logic       event_address;
      logic       event_received;
      logic       event_master_ack;
      logic       event_stop;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      reply_type  reply;
      logic       tx_load;
      logic [7:0] tx_byte;
      logic       busy_res;
      logic       error_seen;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } bank_wr_type;

   typedef struct packed {
      logic [PTR_W-1:0] pointer;
      logic             pointer_received;
      logic             busy;
      logic             fault;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/i2crb_bank.sv @@
// Register storage: BANK_DEPTH bytes, one write port, one combinational read.
// Depends on i2crb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2crb_bank (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire i2crb_pkg::bank_wr_type      wr,
   input  wire logic [i2crb_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                       rd_data
);

   logic [7:0] data_ff [i2crb_pkg::BANK_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < i2crb_pkg::BANK_DEPTH; i++) begin
            data_ff[i] <= 8'h00;
         end
      end else if (wr.en) begin
         data_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_data = data_ff[rd_addr];

endmodule

`default_nettype wire

@@ rtl/core/i2crb_ctrl.sv @@
// Event decoder and pointer/flag state for the register bank.
// Depends on i2crb_pkg; drives the write and read ports of i2crb_bank.
`timescale 1ns / 1ps
`default_nettype none

module i2crb_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire i2crb_pkg::req_type           item,
   input  wire logic [7:0]                   rd_data,
   output logic [i2crb_pkg::ADDR_W-1:0]      rd_addr,
   output i2crb_pkg::bank_wr_type            wr,
   output i2crb_pkg::rsp_type                result,
   output i2crb_pkg::status_type             status
);

   localparam logic [i2crb_pkg::PTR_W-1:0] DEPTH_P = i2crb_pkg::PTR_W'(i2crb_pkg::BANK_DEPTH);
   localparam logic [i2crb_pkg::PTR_W-1:0] ONE_P   = i2crb_pkg::PTR_W'(1);

   logic [i2crb_pkg::PTR_W-1:0] pointer_ff, pointer_in;
   logic                        prcv_ff, prcv_in;
   logic                        busy_ff, busy_in;
   logic                        fault_ff, fault_in;

   logic                        addr_rd, addr_wr, rx_data;
   logic                        ptr_ok, rx_ok, ptr_a_ok, do_write;
   logic [i2crb_pkg::PTR_W-1:0] ptr_a, rd_ptr;
   logic [7:0]                  first_byte;

   always_comb begin
      addr_rd  = item.event_address & item.rx_byte[0];
      addr_wr  = item.event_address & ~item.rx_byte[0];
      rx_data  = ~item.event_address & item.event_received;
      ptr_ok   = pointer_ff < DEPTH_P;
      rx_ok    = 9'(item.rx_byte) < 9'(i2crb_pkg::BANK_DEPTH);
      do_write = rx_data & prcv_ff & ptr_ok;

      // pointer after the address / data-byte part of the item
      ptr_a = pointer_ff;
      if (addr_rd && ptr_ok) begin
         ptr_a = pointer_ff + ONE_P;
      end else if (rx_data && !prcv_ff && rx_ok) begin
         ptr_a = i2crb_pkg::PTR_W'(item.rx_byte);
      end else if (do_write) begin
         ptr_a = pointer_ff + ONE_P;
      end
      ptr_a_ok = ptr_a < DEPTH_P;

      // only one byte per item reaches the result, so one read port serves
      rd_ptr  = item.event_master_ack ? ptr_a : pointer_ff;
      rd_addr = rd_ptr[i2crb_pkg::ADDR_W-1:0];
      first_byte = ptr_ok ? rd_data : i2crb_pkg::TX_EMPTY;
   end

   always_comb begin
      pointer_in = pointer_ff;
      prcv_in    = prcv_ff;
      busy_in    = busy_ff;
      fault_in   = fault_ff;
      wr.en      = 1'b0;
      wr.addr    = pointer_ff[i2crb_pkg::ADDR_W-1:0];
      wr.data    = item.rx_byte;
      result     = '0;
      result.reply = i2crb_pkg::REPLY_NONE;

      if (item.event_fault) begin
         busy_in  = 1'b0;
         fault_in = 1'b1;
      end else begin
         pointer_in = ptr_a;
         if (item.event_address) begin
            result.reply = i2crb_pkg::REPLY_ACK;
            busy_in      = 1'b1;
            if (addr_rd) begin
               result.tx_load = 1'b1;
               result.tx_byte = first_byte;
            end
            if (addr_wr) begin
               prcv_in = 1'b0;
            end
         end else if (item.event_received) begin
            if (!prcv_ff) begin
               if (rx_ok) begin
                  prcv_in      = 1'b1;
                  result.reply = i2crb_pkg::REPLY_ACK;
               end else begin
                  result.reply = i2crb_pkg::REPLY_NACK;
               end
            end else if (ptr_ok) begin
               wr.en        = 1'b1;
               result.reply = i2crb_pkg::REPLY_ACK;
            end else begin
               result.reply = i2crb_pkg::REPLY_NACK;
            end
         end

         if (item.event_master_ack) begin
            result.tx_load = 1'b1;
            result.tx_byte = ptr_a_ok ? rd_data : i2crb_pkg::TX_EMPTY;
            if (ptr_a_ok) begin
               pointer_in = ptr_a + ONE_P;
            end
         end

         if (item.event_stop) begin
            busy_in = 1'b0;
         end
      end

      wr.en             = wr.en & advance;
      result.busy_res   = busy_in;
      result.error_seen = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         prcv_ff    <= 1'b0;
         busy_ff    <= 1'b0;
         fault_ff   <= 1'b0;
      end else if (advance) begin
         pointer_ff <= pointer_in;
         prcv_ff    <= prcv_in;
         busy_ff    <= busy_in;
         fault_ff   <= fault_in;
      end
   end

   assign status.pointer          = pointer_ff;
   assign status.pointer_received = prcv_ff;
   assign status.busy             = busy_ff;
   assign status.fault            = fault_ff;

endmodule

`default_nettype wire

@@ rtl/core/i2c_target_register_bank.sv @@
// Top level of the I2C target register bank: input register, decoder, result register.
// Depends on i2crb_pkg, i2crb_bank, i2crb_ctrl and i2c_target_register_bank_defines.svh.
//
//   channel | ports                        | payload
//   --------+------------------------------+---------------------------------
//   request | req_valid, req_stall, req_data | bus events + received byte
//   result  | rsp_valid, rsp_stall, rsp_data | reply, tx byte, busy, error flag
//
// One transaction in, one transaction out; a new request is taken every cycle while req_stall is low.
// A request passes the request register, then the result register; the bank
// read, bank write and pointer update happen as the request leaves its register.
// Synchronous reset clears the pointer, flags and all bank bytes at once.
// A stalled result holds its register; the request register keeps flowing
// until both stages are full, then req_stall rises in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_target_register_bank_defines.svh"

module i2c_target_register_bank (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire i2crb_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output i2crb_pkg::rsp_type      rsp_data
);

   // request register
   logic               s1_valid_ff, s1_valid_in;
   i2crb_pkg::req_type s1_item_ff, s1_item_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   i2crb_pkg::rsp_type out_data_ff, out_data_in;

   logic out_free, s1_fire, req_fire;

   // decoder <-> bank
   i2crb_pkg::bank_wr_type        bank_wr;
   logic [i2crb_pkg::ADDR_W-1:0]  bank_rd_addr;
   logic [7:0]                    bank_rd_data;
   i2crb_pkg::rsp_type            next_rsp;
   i2crb_pkg::status_type         status;

   // handshake: result slot frees when empty or being taken
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign s1_fire   = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;
   assign req_fire  = req_valid & ~req_stall;

   assign s1_valid_in  = req_fire | (s1_valid_ff & ~s1_fire);
   assign s1_item_in   = req_fire ? req_data : s1_item_ff;
   assign out_valid_in = s1_fire | (out_valid_ff & rsp_stall);
   assign out_data_in  = s1_fire ? next_rsp : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_data_ff <= out_data_in;
   end

   i2crb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_fire),
      .item    (s1_item_ff),
      .rd_data (bank_rd_data),
      .rd_addr (bank_rd_addr),
      .wr      (bank_wr),
      .result  (next_rsp),
      .status  (status)
   );

   i2crb_bank u_bank (
      .clock   (clock),
      .reset   (reset),
      .wr      (bank_wr),
      .rd_addr (bank_rd_addr),
      .rd_data (bank_rd_data)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a fault transaction yields a bare result with the error flag up
   `I2CRB_ASSERT_NEXT(a_fault_result, clock, reset, s1_fire && s1_item_ff.event_fault,
      rsp_valid && rsp_data.reply == i2crb_pkg::REPLY_NONE && !rsp_data.tx_load
      && rsp_data.error_seen, "fault transaction gave wrong result")
   // error flag never clears outside reset
   `I2CRB_ASSERT_NEXT(a_fault_sticky, clock, reset, status.fault, status.fault,
      "fault flag cleared")
   // pointer never runs past the end of the bank
   `I2CRB_ASSERT_NOW(a_ptr_range, clock, reset, 1'b1,
      status.pointer <= i2crb_pkg::PTR_W'(i2crb_pkg::BANK_DEPTH), "pointer out of range")
   // unloaded transmit byte reads as zero
   `I2CRB_ASSERT_NOW(a_tx_zero, clock, reset, rsp_valid && !rsp_data.tx_load,
      rsp_data.tx_byte == 8'h00, "tx byte set without load")

endmodule

`default_nettype wire
